// ===== sv/ctq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctq_pkg: shared types and constants of the CAN task queue
// Opcodes, register indexes, reset values and the structs passed between the
// step logic and the top level.
// ----------------------------------------------------------------------------
package ctq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;

  // opcodes of an input item
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_FRAME = 2'd2;

  // configuration register indexes
  localparam logic CFG_RETRY_LIMIT = 1'b0;
  localparam logic CFG_SEND_PERIOD = 1'b1;

  localparam logic [7:0] RETRY_LIMIT_RST = 8'd3;
  localparam logic [7:0] SEND_PERIOD_RST = 8'd10;

  localparam logic [3:0]  ACK_CODE   = 4'hF;
  localparam logic [10:0] MAX_ACK_ID = 11'h1FF;

  localparam int unsigned HDR_W    = 12;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned QCOUNT_W = 5;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [3:0]        receiver_id;
    logic [3:0]        sender_id;
    logic [3:0]        task_code;
    logic [DATA_W-1:0] payload;
    logic [10:0]       frame_id;
    logic              frame_is_classic;
    logic              frame_is_standard;
    logic              frame_on_this_bus;
  } item_t;

  typedef struct packed {
    logic              accepted;
    logic              send_valid;
    logic [HDR_W-1:0]  send_id;
    logic [DATA_W-1:0] send_data;
    logic              task_dropped;
    logic              task_completed;
    logic              ack_matched;
  } result_t;

endpackage

// ===== sv/ctq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctq_ram: generic single-write, single-read ram
// One write port, one read port with registered data; a read of the address
// written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module ctq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ctq_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctq_step: next-state and result logic of the task queue
// Works one registered item against the queue state and the head entry.
// ----------------------------------------------------------------------------
module ctq_step #(
  parameter int unsigned DEPTH = ctq_pkg::DEPTH_DEFAULT,
  localparam int unsigned PTR_W = $clog2(DEPTH),
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  ctq_pkg::item_t                  item_i,
  input  logic [PTR_W-1:0]                head_i,
  input  logic [PTR_W-1:0]                tail_i,
  input  logic [CNT_W-1:0]                count_i,
  input  logic [7:0]                      phase_i,
  input  logic [7:0]                      retry_i,
  input  logic                            acked_i,
  input  logic [ctq_pkg::HDR_W-1:0]       hdr_i,
  input  logic [ctq_pkg::DATA_W-1:0]      data_i,
  input  logic [7:0]                      retry_limit_i,
  input  logic [7:0]                      send_period_i,
  output logic [PTR_W-1:0]                head_o,
  output logic [PTR_W-1:0]                tail_o,
  output logic [CNT_W-1:0]                count_o,
  output logic [7:0]                      phase_o,
  output logic [7:0]                      retry_o,
  output logic                            acked_o,
  output logic                            wr_en_o,
  output ctq_pkg::result_t                result_o
);

  import ctq_pkg::*;

  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] tail_next;
  logic [7:0]       phase_inc;
  logic [7:0]       period;
  logic             not_empty;
  logic             frame_ok;

  assign head_next = (head_i == PTR_W'(DEPTH - 1)) ? '0 : head_i + PTR_W'(1);
  assign tail_next = (tail_i == PTR_W'(DEPTH - 1)) ? '0 : tail_i + PTR_W'(1);
  assign phase_inc = phase_i + 8'd1;
  assign period    = (send_period_i == 8'd0) ? 8'd1 : send_period_i;
  assign not_empty = (count_i != '0);
  assign frame_ok  = item_i.frame_is_classic && item_i.frame_is_standard &&
                     item_i.frame_on_this_bus && (item_i.frame_id <= MAX_ACK_ID) &&
                     not_empty;

  always_comb begin
    head_o   = head_i;
    tail_o   = tail_i;
    count_o  = count_i;
    phase_o  = phase_i;
    retry_o  = retry_i;
    acked_o  = acked_i;
    wr_en_o  = 1'b0;
    result_o = '0;
    case (item_i.opcode)
      OP_ADD: begin
        if (count_i < CNT_W'(DEPTH)) begin
          wr_en_o           = 1'b1;
          tail_o            = tail_next;
          count_o           = count_i + CNT_W'(1);
          result_o.accepted = 1'b1;
        end
      end
      OP_TICK: begin
        if (not_empty) begin
          if (acked_i || (retry_i >= retry_limit_i)) begin
            // pop the head: acknowledged, or out of sends
            head_o  = head_next;
            count_o = count_i - CNT_W'(1);
            phase_o = 8'd0;
            retry_o = 8'd0;
            acked_o = 1'b0;
            result_o.task_completed = acked_i;
            result_o.task_dropped   = !acked_i;
          end else if (phase_inc >= period) begin
            phase_o             = 8'd0;
            retry_o             = retry_i + 8'd1;
            result_o.send_valid = 1'b1;
            result_o.send_id    = hdr_i;
            result_o.send_data  = data_i;
          end else begin
            phase_o = phase_inc;
          end
        end
      end
      OP_FRAME: begin
        // ack frame carries the head task's ids swapped
        if (frame_ok &&
            (hdr_i[7:4] == {1'b0, item_i.frame_id[10:8]}) &&
            (hdr_i[11:8] == item_i.frame_id[7:4]) &&
            (item_i.frame_id[3:0] == ACK_CODE)) begin
          acked_o              = 1'b1;
          result_o.ack_matched = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/can_task_queue_with_ack_retry_unit.sv =====
`timescale 1ns / 1ps
// done_o follows start through the input register, then the result register
// throughput: one item per cycle; busy stays low, the receiver cannot stall
// the head entry is read from the queue ram ahead of use, at the next head pointer
// reset: pointers, counters and ack flag clear, retry_limit 3, send_period 10;
// the queue ram is not cleared, entries are only used once written
// ----------------------------------------------------------------------------
// can_task_queue_with_ack_retry_unit: CAN transmit queue with ack and retry
// Circular queue of outgoing tasks; ticks send the head task periodically
// until an ack frame arrives or the send budget runs out.
// ----------------------------------------------------------------------------
module can_task_queue_with_ack_retry_unit #(
  parameter int unsigned DEPTH = ctq_pkg::DEPTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  // command side
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [3:0]  receiver_id_i,
  input  logic [3:0]  sender_id_i,
  input  logic [3:0]  task_code_i,
  input  logic [63:0] payload_i,
  input  logic [10:0] frame_id_i,
  input  logic        frame_is_classic_i,
  input  logic        frame_is_standard_i,
  input  logic        frame_on_this_bus_i,
  // result side
  output logic        done_o,
  output logic        accepted_o,
  output logic        send_valid_o,
  output logic [11:0] send_id_o,
  output logic [63:0] send_data_o,
  output logic        task_dropped_o,
  output logic        task_completed_o,
  output logic        ack_matched_o,
  output logic [4:0]  queue_count_o
);

  import ctq_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // configuration registers
  logic [7:0] retry_limit_q;
  logic [7:0] send_period_q;

  // input register
  logic  item_vld_q;
  item_t item_q;

  // queue state
  logic [PTR_W-1:0] head_q, head_d, head_step;
  logic [PTR_W-1:0] tail_q, tail_d, tail_step;
  logic [CNT_W-1:0] count_q, count_d, count_step;
  logic [7:0]       phase_q, phase_d, phase_step;
  logic [7:0]       retry_q, retry_d, retry_step;
  logic             acked_q, acked_d, acked_step;
  logic             wr_step;
  logic             wr_en;

  // head entry from the queue ram
  logic [HDR_W-1:0]  head_hdr;
  logic [DATA_W-1:0] head_data;

  // result register
  result_t             result_step;
  result_t             result_q;
  logic                done_q;
  logic [4:0]          qcount_q;
  logic [CNT_W+4:0]    count_ext;

  // never stalls: an item can enter every cycle
  assign busy = 1'b0;

  // config writes land directly; only done while idle is a rule for the user, not enforced here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q <= RETRY_LIMIT_RST;
      send_period_q <= SEND_PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RETRY_LIMIT: retry_limit_q <= cfg_data_i;
        CFG_SEND_PERIOD: send_period_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // input register: capture the item on start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else begin
      item_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      item_q.opcode            <= opcode_i;
      item_q.receiver_id       <= receiver_id_i;
      item_q.sender_id         <= sender_id_i;
      item_q.task_code         <= task_code_i;
      item_q.payload           <= payload_i;
      item_q.frame_id          <= frame_id_i;
      item_q.frame_is_classic  <= frame_is_classic_i;
      item_q.frame_is_standard <= frame_is_standard_i;
      item_q.frame_on_this_bus <= frame_on_this_bus_i;
    end
  end

  // header and payload rams, both read at the next head pointer so that the
  // registered read data always belongs to head_q
  ctq_ram #(
    .WIDTH (HDR_W),
    .DEPTH (DEPTH)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (tail_q),
    .wdata_i ({item_q.receiver_id, item_q.sender_id, item_q.task_code}),
    .raddr_i (head_d),
    .rdata_o (head_hdr)
  );

  ctq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (tail_q),
    .wdata_i (item_q.payload),
    .raddr_i (head_d),
    .rdata_o (head_data)
  );

  // one pass of queue logic for the registered item
  ctq_step #(
    .DEPTH (DEPTH)
  ) u_step (
    .item_i        (item_q),
    .head_i        (head_q),
    .tail_i        (tail_q),
    .count_i       (count_q),
    .phase_i       (phase_q),
    .retry_i       (retry_q),
    .acked_i       (acked_q),
    .hdr_i         (head_hdr),
    .data_i        (head_data),
    .retry_limit_i (retry_limit_q),
    .send_period_i (send_period_q),
    .head_o        (head_step),
    .tail_o        (tail_step),
    .count_o       (count_step),
    .phase_o       (phase_step),
    .retry_o       (retry_step),
    .acked_o       (acked_step),
    .wr_en_o       (wr_step),
    .result_o      (result_step)
  );

  // state only moves when an item is in the input register
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    phase_d = phase_q;
    retry_d = retry_q;
    acked_d = acked_q;
    wr_en   = 1'b0;
    if (item_vld_q) begin
      head_d  = head_step;
      tail_d  = tail_step;
      count_d = count_step;
      phase_d = phase_step;
      retry_d = retry_step;
      acked_d = acked_step;
      wr_en   = wr_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      phase_q <= 8'd0;
      retry_q <= 8'd0;
      acked_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      phase_q <= phase_d;
      retry_q <= retry_d;
      acked_q <= acked_d;
    end
  end

  // result register, strobed for one cycle
  assign count_ext = {5'b0, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= item_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_vld_q) begin
      result_q <= result_step;
      qcount_q <= count_ext[4:0];
    end
  end

  assign done_o           = done_q;
  assign accepted_o       = result_q.accepted;
  assign send_valid_o     = result_q.send_valid;
  assign send_id_o        = result_q.send_id;
  assign send_data_o      = result_q.send_data;
  assign task_dropped_o   = result_q.task_dropped;
  assign task_completed_o = result_q.task_completed;
  assign ack_matched_o    = result_q.ack_matched;
  assign queue_count_o    = qcount_q;

endmodule
